// ===== rtl/core/spr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the slab page rebalance policy.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int CLS_FIELD_W = 6;
    localparam int OUT_CLS_W   = 7;
    localparam logic [OUT_CLS_W-1:0] CLS_NONE = 7'h7F;

    localparam logic [5:0]  WLEN_RESET  = 6'd30;
    localparam logic [14:0] RATIO_RESET = 15'd3277;

    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_AGE_RATIO     = 1'b1;

    typedef struct packed {
        logic                   last;
        logic [CLS_FIELD_W-1:0] cls;
        logic                   store;
        logic [20:0]            cpp;
        logic [31:0]            free;
        logic [31:0]            pages;
        logic [31:0]            age;
        logic [63:0]            oom;
        logic [63:0]            evicted;
    } t_item;

    typedef struct packed {
        logic [63:0] evicted;
        logic [63:0] oom;
        logic [31:0] pages;
    } t_prev;

    typedef struct packed {
        logic [63:0] ed;
        logic        chg;
        logic [31:0] age;
        logic        big_pages;
        logic        reclaim;
    } t_run;

    typedef struct packed {
        logic [31:0] age;
        logic        dirty;
        logic [16:0] share;
        logic        seen;
    } t_slot;

    typedef struct packed {
        logic        start;
        logic [63:0] rem_init;
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [6:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/core/spr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_ram
// Generic memory, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/spr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module spr_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output      logic             o_valid,
    output      logic             o_full,
    output      logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/spr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_front
// Accept stats words, number them by class and mark which are stored.
// ----------------------------------------------------------------------------
module spr_front #(
    parameter int NUM_CLASSES = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output      logic           o_s_tready,
    input  wire logic [247:0]   i_s_tdata,
    input  wire logic           i_s_tlast,
    input  wire logic           i_q_full,
    input  wire logic           i_clearing,
    output      logic           o_push,
    output      spr_pkg::t_item o_item
);
    import spr_pkg::*;
    localparam int CLS_W = $clog2(NUM_CLASSES);

    logic [CLS_W-1:0] r_pos;
    logic             store;

    assign o_s_tready = !i_q_full && !i_clearing;
    assign o_push     = i_s_tvalid && o_s_tready;
    assign store      = r_pos != CLS_W'(NUM_CLASSES - 1);

    always_comb begin
        o_item.evicted = i_s_tdata[63:0];
        o_item.oom     = i_s_tdata[127:64];
        o_item.age     = i_s_tdata[159:128];
        o_item.pages   = i_s_tdata[191:160];
        o_item.free    = i_s_tdata[223:192];
        o_item.cpp     = i_s_tdata[244:224];
        o_item.store   = store;
        o_item.cls     = CLS_FIELD_W'(r_pos + CLS_W'(1));
        o_item.last    = i_s_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            if (i_s_tlast) begin
                r_pos <= '0;
            end else if (store) begin
                r_pos <= r_pos + CLS_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/spr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spr_pkg::t_div_req i_req,
    output      spr_pkg::t_div_rsp o_rsp
);
    import spr_pkg::*;

    logic        r_busy, r_done;
    logic [63:0] r_rem, r_dvd, r_div, r_quo;
    logic [6:0]  r_cnt;
    logic [64:0] t;
    logic [64:0] diff;
    logic        ge;

    assign t    = {r_rem, r_dvd[63]};
    assign diff = t - {1'b0, r_div};
    assign ge   = t >= {1'b0, r_div};

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_quo <= '0;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_rem <= ge ? diff[63:0] : t[63:0];
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_quo <= {r_quo[62:0], ge};
            r_cnt <= r_cnt - 7'd1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_cnt == 7'd1;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/spr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_back
// Store run words, then update class windows and choose one page move.
// ----------------------------------------------------------------------------
module spr_back #(
    parameter int NUM_CLASSES = 64,
    parameter int MAX_WINDOW  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire spr_pkg::t_item    i_q_item,
    output      logic              o_q_pop,
    output      logic              o_clearing,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [14:0]       i_cfg_data,
    output      spr_pkg::t_div_req o_div_req,
    input  wire spr_pkg::t_div_rsp i_div_rsp,
    output      logic              o_res_valid,
    input  wire logic              i_res_ready,
    output      logic [6:0]        o_res_src,
    output      logic [6:0]        o_res_dst
);
    import spr_pkg::*;

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int SLOTS   = NUM_CLASSES * MAX_WINDOW;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int AS_W    = 32 + WIN_W;
    localparam int SH_W    = 17 + WIN_W;

    typedef enum logic [14:0] {
        S_CLEAR   = 15'b000000000000001,
        S_IDLE    = 15'b000000000000010,
        S_ING     = 15'b000000000000100,
        S_RUN_END = 15'b000000000001000,
        S_MOD_W   = 15'b000000000010000,
        S_CLS_RD  = 15'b000000000100000,
        S_CLS_RDW = 15'b000000001000000,
        S_SHR_W   = 15'b000000010000000,
        S_SLOT_WR = 15'b000000100000000,
        S_SUM     = 15'b000001000000000,
        S_AGE_W   = 15'b000010000000000,
        S_EVAL    = 15'b000100000000000,
        S_FIN     = 15'b001000000000000,
        S_CMP     = 15'b010000000000000,
        S_OUT     = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic [SLOT_AW-1:0] r_clr, n_clr;
    t_item              r_item, n_item;
    logic [63:0]        r_total, n_total;
    logic [CLS_W-1:0]   r_loaded, n_loaded;
    logic               r_primed, n_primed;
    logic [31:0]        r_run_cnt, n_run_cnt;
    logic [WIN_W-1:0]   r_win, n_win;
    logic [WIN_W-1:0]   r_slot, n_slot;
    logic [CLS_W-1:0]   r_n, n_n;
    t_run               r_run, n_run;
    logic [16:0]        r_share, n_share;
    logic [WIN_W-1:0]   r_x, n_x;
    logic               r_rd_vld, n_rd_vld;
    logic [AS_W-1:0]    r_sum_age, n_sum_age;
    logic [WIN_W-1:0]   r_sum_dirty, n_sum_dirty;
    logic [WIN_W-1:0]   r_sum_seen, n_sum_seen;
    logic [SH_W-1:0]    r_sum_share, n_sum_share;
    logic [31:0]        r_age, n_age;
    logic               r_old_ok, n_old_ok;
    logic [CLS_W-1:0]   r_old_id, n_old_id;
    logic [31:0]        r_old_age, n_old_age;
    logic               r_yng_ok, n_yng_ok;
    logic [CLS_W-1:0]   r_yng_id, n_yng_id;
    logic [31:0]        r_yng_age, n_yng_age;
    logic               r_yng_evict, n_yng_evict;
    logic [6:0]         r_src, n_src, r_dst, n_dst;
    logic [46:0]        r_prod, n_prod;
    logic               r_out_vld, n_out_vld;
    logic [6:0]         r_out_src, n_out_src, r_out_dst, n_out_dst;
    logic [5:0]         r_wlen;
    logic [14:0]        r_ratio;

    logic               slot_we, prev_we, run_we;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    t_slot              slot_wdata, slot_rdata;
    logic [CLS_W-1:0]   prev_raddr, run_raddr;
    t_prev              prev_wdata, prev_rdata;
    t_run               run_wdata, run_rdata;
    logic [CLS_W-1:0]   cls;
    logic [WIN_W-1:0]   win;
    logic [SLOT_AW-1:0] base;
    logic [63:0]        ed;
    logic [32:0]        free2, cpp5;
    logic [17:0]        q_rnd;

    spr_ram #(.WIDTH($bits(t_slot)), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk, .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );
    spr_ram #(.WIDTH($bits(t_prev)), .DEPTH(NUM_CLASSES)) u_prev_ram (
        .i_clk, .i_we(prev_we), .i_waddr(cls), .i_wdata(prev_wdata),
        .i_raddr(prev_raddr), .o_rdata(prev_rdata)
    );
    spr_ram #(.WIDTH($bits(t_run)), .DEPTH(NUM_CLASSES)) u_run_ram (
        .i_clk, .i_we(run_we), .i_waddr(cls), .i_wdata(run_wdata),
        .i_raddr(run_raddr), .o_rdata(run_rdata)
    );

    assign o_clearing  = r_state == S_CLEAR;
    assign o_res_valid = r_out_vld;
    assign o_res_src   = r_out_src;
    assign o_res_dst   = r_out_dst;

    assign cls   = r_item.cls[CLS_W-1:0];
    assign base  = SLOT_AW'(r_n) * SLOT_AW'(MAX_WINDOW);
    assign ed    = r_item.evicted - prev_rdata.evicted;
    assign free2 = {r_item.free, 1'b0};
    assign cpp5  = 33'(r_item.cpp) * 33'd5;
    assign q_rnd = 18'(i_div_rsp.quo[16:0]) + 18'd1;

    always_comb begin
        if (r_wlen == 6'd0) begin
            win = WIN_W'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = WIN_W'(r_wlen);
        end
    end

    always_comb begin
        n_state = r_state;   n_clr = r_clr;       n_item = r_item;
        n_total = r_total;   n_loaded = r_loaded; n_primed = r_primed;
        n_run_cnt = r_run_cnt; n_win = r_win;     n_slot = r_slot;
        n_n = r_n;           n_run = r_run;       n_share = r_share;
        n_x = r_x;           n_rd_vld = 1'b0;     n_sum_age = r_sum_age;
        n_sum_dirty = r_sum_dirty; n_sum_seen = r_sum_seen;
        n_sum_share = r_sum_share; n_age = r_age;
        n_old_ok = r_old_ok; n_old_id = r_old_id; n_old_age = r_old_age;
        n_yng_ok = r_yng_ok; n_yng_id = r_yng_id; n_yng_age = r_yng_age;
        n_yng_evict = r_yng_evict; n_src = r_src; n_dst = r_dst;
        n_prod = r_prod;
        n_out_vld = r_out_vld && !i_res_ready;
        n_out_src = r_out_src; n_out_dst = r_out_dst;

        o_q_pop    = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = base + SLOT_AW'(r_slot);
        slot_wdata = '0;
        slot_raddr = base + SLOT_AW'(r_x);
        prev_we    = 1'b0;
        prev_raddr = i_q_item.cls[CLS_W-1:0];
        prev_wdata = '{evicted: r_item.evicted, oom: r_item.oom, pages: r_item.pages};
        run_we     = 1'b0;
        run_raddr  = r_n;
        run_wdata  = '{ed: ed,
                       chg: r_item.oom != prev_rdata.oom || r_item.pages != prev_rdata.pages,
                       age: r_item.age, big_pages: r_item.pages > 32'd2,
                       reclaim: free2 > cpp5};
        o_div_req  = '{start: 1'b0, rem_init: '0, dividend: '0,
                       divisor: 64'(win), steps: 7'd32};

        unique case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                n_clr      = r_clr + SLOT_AW'(1);
                if (r_clr == SLOT_AW'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    if (i_q_item.store) begin
                        n_state = S_ING;
                    end else if (i_q_item.last) begin
                        n_state = S_RUN_END;
                    end
                end
            end
            S_ING: begin
                prev_we  = 1'b1;
                run_we   = 1'b1;
                n_total  = r_total + ed;
                n_loaded = cls;
                n_state  = r_item.last ? S_RUN_END : S_IDLE;
            end
            S_RUN_END: begin
                n_src = CLS_NONE;
                n_dst = CLS_NONE;
                n_old_ok = 1'b0;
                n_yng_ok = 1'b0;
                n_old_age = '0;
                n_n = CLS_W'(1);
                if (!r_primed) begin
                    n_primed = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_run_cnt = r_run_cnt + 32'd1;
                    n_win     = win;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {r_run_cnt + 32'd1, 32'd0};
                    n_state   = S_MOD_W;
                end
            end
            S_MOD_W: begin
                if (i_div_rsp.done) begin
                    n_slot  = i_div_rsp.rem[WIN_W-1:0];
                    n_state = (r_loaded == '0) ? S_FIN : S_CLS_RD;
                end
            end
            S_CLS_RD: begin
                n_state = S_CLS_RDW;
            end
            S_CLS_RDW: begin
                n_run = run_rdata;
                if (run_rdata.ed == 64'd0) begin
                    n_share = '0;
                    n_state = S_SLOT_WR;
                end else if (run_rdata.ed >= r_total) begin
                    n_share = 17'd65536;
                    n_state = S_SLOT_WR;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.rem_init = run_rdata.ed;
                    o_div_req.divisor  = r_total;
                    o_div_req.steps    = 7'd17;
                    n_state = S_SHR_W;
                end
            end
            S_SHR_W: begin
                if (i_div_rsp.done) begin
                    n_share = q_rnd[17:1];
                    n_state = S_SLOT_WR;
                end
            end
            S_SLOT_WR: begin
                slot_we    = 1'b1;
                slot_wdata = '{age: r_run.age, dirty: r_run.ed != 64'd0 || r_run.chg,
                               share: r_share, seen: r_run.ed != 64'd0};
                n_x = '0;
                n_sum_age = '0;
                n_sum_dirty = '0;
                n_sum_seen = '0;
                n_sum_share = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (r_x != r_win) begin
                    n_x = r_x + WIN_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_sum_age   = r_sum_age + AS_W'(slot_rdata.age);
                    n_sum_dirty = r_sum_dirty + WIN_W'(slot_rdata.dirty);
                    n_sum_seen  = r_sum_seen + WIN_W'(slot_rdata.seen);
                    n_sum_share = r_sum_share + SH_W'(slot_rdata.share);
                end
                if (r_x == r_win && !r_rd_vld) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = 64'(r_sum_age) << (64 - AS_W);
                    o_div_req.divisor  = 64'(r_win);
                    o_div_req.steps    = 7'(AS_W);
                    n_state = S_AGE_W;
                end
            end
            S_AGE_W: begin
                if (i_div_rsp.done) begin
                    n_age   = i_div_rsp.quo[31:0];
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_run.reclaim && r_sum_dirty == '0) begin
                    n_src = OUT_CLS_W'(r_n);
                    n_dst = '0;
                    n_old_ok = 1'b0;
                    n_yng_ok = 1'b0;
                    n_state = S_FIN;
                end else begin
                    if (r_age > r_old_age && r_run.big_pages) begin
                        n_old_ok  = 1'b1;
                        n_old_id  = r_n;
                        n_old_age = r_age;
                    end
                    if ((!r_yng_ok || r_age < r_yng_age) &&
                        (r_sum_seen > (r_win >> 1) ||
                         r_sum_share > (SH_W'(r_win) << 14))) begin
                        n_yng_ok    = 1'b1;
                        n_yng_id    = r_n;
                        n_yng_age   = r_age;
                        n_yng_evict = r_run.ed != 64'd0;
                    end
                    n_n = r_n + CLS_W'(1);
                    n_state = (r_n == r_loaded) ? S_FIN : S_CLS_RD;
                end
            end
            S_FIN: begin
                n_prod = 47'(r_old_age) * 47'(r_ratio);
                n_state = (r_yng_ok && r_old_ok && r_run_cnt > 32'(r_win)) ? S_CMP : S_OUT;
            end
            S_CMP: begin
                if ({3'd0, r_yng_age, 12'd0} < r_prod && r_yng_evict) begin
                    n_src = OUT_CLS_W'(r_old_id);
                    n_dst = OUT_CLS_W'(r_yng_id);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld) begin
                    n_out_vld = 1'b1;
                    n_out_src = r_src;
                    n_out_dst = r_dst;
                    n_total   = '0;
                    n_loaded  = '0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;   r_win <= n_win;
        r_slot <= n_slot;   r_n <= n_n;       r_run <= n_run;
        r_share <= n_share; r_x <= n_x;       r_sum_age <= n_sum_age;
        r_sum_dirty <= n_sum_dirty; r_sum_seen <= n_sum_seen;
        r_sum_share <= n_sum_share; r_age <= n_age;
        r_old_ok <= n_old_ok; r_old_id <= n_old_id; r_old_age <= n_old_age;
        r_yng_ok <= n_yng_ok; r_yng_id <= n_yng_id; r_yng_age <= n_yng_age;
        r_yng_evict <= n_yng_evict; r_src <= n_src; r_dst <= n_dst;
        r_prod <= n_prod; r_out_src <= n_out_src; r_out_dst <= n_out_dst;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_primed  <= 1'b0;
            r_run_cnt <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_total   <= '0;
            r_loaded  <= '0;
            r_wlen    <= WLEN_RESET;
            r_ratio   <= RATIO_RESET;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_primed  <= n_primed;
            r_run_cnt <= n_run_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_total   <= n_total;
            r_loaded  <= n_loaded;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_LENGTH: r_wlen  <= i_cfg_data[5:0];
                    CFG_AGE_RATIO:     r_ratio <= i_cfg_data;
                    default:           r_ratio <= r_ratio;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/slab_page_rebalance_policy.sv =====
// Decision: after a run's final word the back end uses the shared serial divider
//   for the window slot, then per loaded class for its share and mean age.
// Flow: each stored word passes the idle and ingest states; a run's scan blocks new
//   words only once the two-entry queue fills.
// Reset: synchronous active low; a slot clearing pass over all NUM_CLASSES*MAX_WINDOW
//   slots follows, with input ready low, configuration still taken.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slab_page_rebalance_policy
// Top level: stats front end, word queue, decision back end, shared divider.
// ----------------------------------------------------------------------------
module slab_page_rebalance_policy #(
    parameter int NUM_CLASSES = 64,
    parameter int MAX_WINDOW  = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output      logic         o_s_tready,
    // evicted_count, out_of_memory_count, item_age, page_count,
    // free_chunk_count, chunks_in_page, zero pad
    input  wire logic [247:0] i_s_tdata,
    input  wire logic         i_s_tlast,
    output      logic         o_m_tvalid,
    input  wire logic         i_m_tready,
    // source_class, dest_class, zero pad
    output      logic [15:0]  o_m_tdata,
    input  wire logic         i_cfg_valid,
    output      logic         o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [14:0]  i_cfg_data
);
    import spr_pkg::*;

    logic     push, pop, q_valid, q_full, clearing;
    t_item    f_item, q_item;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic [6:0] res_src, res_dst;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {2'b00, res_dst, res_src};

    spr_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tlast,
        .i_q_full(q_full), .i_clearing(clearing), .o_push(push), .o_item(f_item)
    );

    spr_fifo #(.WIDTH($bits(t_item))) u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_data(f_item), .i_pop(pop),
        .o_valid(q_valid), .o_full(q_full), .o_data(q_item)
    );

    spr_div u_div (
        .i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp)
    );

    spr_back #(.NUM_CLASSES(NUM_CLASSES), .MAX_WINDOW(MAX_WINDOW)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(pop),
        .o_clearing(clearing), .i_cfg_we(i_cfg_valid && o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_div_req(div_req), .i_div_rsp(div_rsp),
        .o_res_valid(o_m_tvalid), .i_res_ready(i_m_tready),
        .o_res_src(res_src), .o_res_dst(res_dst)
    );
endmodule
`default_nettype wire

// ===== rtl/core/spr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the rebalance policy, bound to the top level.
// ----------------------------------------------------------------------------
module spr_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic [247:0] i_s_tdata,
    input wire logic         i_s_tlast,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [15:0]  o_m_tdata,
    input wire logic         i_cfg_valid,
    input wire logic         o_cfg_ready,
    input wire logic         i_cfg_index,
    input wire logic [14:0]  i_cfg_data
);
    import spr_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result word changed while stalled");

    a_no_move_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[6:0] == CLS_NONE) == (o_m_tdata[13:7] == CLS_NONE)))
        else $error("one side of a move is missing");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("ports active right after reset");
endmodule

bind slab_page_rebalance_policy spr_checker u_spr_checker (.*);
`default_nettype wire
